// File: sv/cbpd_pkg.sv
package cbpd_pkg;

   localparam int CountDepth = 256;
   localparam int AddrW      = 8;
   localparam int CountW     = 6;
   localparam int CountMax   = 63;
   localparam int WidthW     = 9;
   localparam int HeightW    = 7;
   localparam int HeightMax  = 127;
   localparam int PeakCapW   = 4;
   localparam int PeakSlots  = 8;

   localparam logic [1:0] RegFrameWidth    = 2'd0;
   localparam logic [1:0] RegPeakThreshold = 2'd1;
   localparam logic [1:0] RegMinSeparation = 2'd2;
   localparam logic [1:0] RegMaxPeaks      = 2'd3;

endpackage

// File: sv/cbpd_count_ram.sv
module cbpd_count_ram
   import cbpd_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AddrW-1:0]  wr_addr,
   input  logic [CountW-1:0] wr_data,
   input  logic [AddrW-1:0]  rd_addr,
   output logic [CountW-1:0] rd_data
);

   logic [CountW-1:0] mem [CountDepth];
   logic [CountW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/column_blank_peak_detector.sv
// Channel   Direction  Handshake                Payload
// req       in         start & !busy            column, cell_blank, end_of_frame
// rsp       out        rsp_strobe (one cycle)   peak_column, peak_height, peak_valid, last_result
// csr       in         csr_valid & csr_ready    csr_index, csr_data
//
// A word without end_of_frame makes one read and one write of the count memory.
// A word with end_of_frame then starts a scan that reads and clears all 256 count
// entries, one per cycle through the memory's read and write ports, then drains the pipeline.
// After reset the block is busy while it clears all 256 entries of the count memory.
// The receiver cannot stall; results leave at most one per cycle during the scan.
module column_blank_peak_detector
   import cbpd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [7:0]          req_column,
   input  logic                req_cell_blank,
   input  logic                req_end_of_frame,
   output logic                rsp_strobe,
   output logic [7:0]          rsp_peak_column,
   output logic [HeightW-1:0]  rsp_peak_height,
   output logic                rsp_peak_valid,
   output logic                rsp_last_result,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [1:0]          csr_index,
   input  logic [WidthW-1:0]   csr_data
);

   localparam logic [2:0] S_CLEAR = 3'd0;
   localparam logic [2:0] S_IDLE  = 3'd1;
   localparam logic [2:0] S_INC   = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_DRAIN = 3'd4;
   localparam logic [2:0] S_FINAL = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [WidthW-1:0]   idx_ff, idx_in;
   logic [WidthW-1:0]   frame_width_ff;
   logic [HeightW-1:0]  peak_threshold_ff;
   logic [7:0]          min_separation_ff;
   logic [PeakCapW-1:0] max_peaks_ff;
   logic [7:0]          col_ff, col_in;
   logic                blank_ff, blank_in;
   logic                eof_ff, eof_in;
   logic                v1_ff, v1_in;
   logic [WidthW-1:0]   j1_ff, j1_in;
   logic                v2_ff;
   logic [WidthW-1:0]   j2_ff;
   logic [CountW-1:0]   cm1_ff, cm2_ff;
   logic [HeightW-1:0]  sh0_ff, sh1_ff, sh2_ff;
   logic [PeakCapW-1:0] found_ff, found_in;
   logic [7:0]          prev_ff, prev_in;
   logic [7:0]          pend_col_ff, pend_col_in;
   logic [HeightW-1:0]  pend_h_ff, pend_h_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]          rsp_col_ff, rsp_col_in;
   logic [HeightW-1:0]  rsp_h_ff, rsp_h_in;
   logic                rsp_pv_ff, rsp_pv_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                wr_en;
   logic [AddrW-1:0]    wr_addr;
   logic [CountW-1:0]   wr_data;
   logic [AddrW-1:0]    rd_addr;
   logic [CountW-1:0]   rd_data;

   logic [WidthW-1:0]   w_eff;
   logic [PeakCapW-1:0] cap;
   logic [CountW-1:0]   cval;
   logic [7:0]          sum3;
   logic [HeightW-1:0]  sum_sat;
   logic [WidthW-1:0]   q9;
   logic [7:0]          q;
   logic [7:0]          gap;
   logic                hit;

   cbpd_count_ram u_count_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      w_eff = (frame_width_ff > WidthW'(CountDepth)) ? WidthW'(CountDepth) : frame_width_ff;
      if (max_peaks_ff == '0) begin
         cap = PeakCapW'(1);
      end else if (max_peaks_ff > PeakCapW'(PeakSlots)) begin
         cap = PeakCapW'(PeakSlots);
      end else begin
         cap = max_peaks_ff;
      end
   end

   // Stage one: count entering the three-column window.
   always_comb begin
      cval    = (j1_ff < w_eff) ? rd_data : '0;
      sum3    = 8'(cval) + 8'(cm1_ff) + 8'(cm2_ff);
      sum_sat = (sum3 > 8'(HeightMax)) ? HeightW'(HeightMax) : sum3[HeightW-1:0];
   end

   // Stage two: sh1 holds the smoothed count of column q = j2 - 2.
   always_comb begin
      q9  = j2_ff - WidthW'(2);
      q   = q9[7:0];
      gap = q - prev_ff;
      hit = v2_ff && (j2_ff >= WidthW'(3)) && (j2_ff <= w_eff)
         && (sh1_ff >= sh0_ff) && (sh1_ff > sh2_ff) && (sh1_ff >= peak_threshold_ff)
         && ((found_ff == '0) || (gap > min_separation_ff)) && (found_ff < cap);
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      col_in        = col_ff;
      blank_in      = blank_ff;
      eof_in        = eof_ff;
      v1_in         = 1'b0;
      j1_in         = j1_ff;
      found_in      = found_ff;
      prev_in       = prev_ff;
      pend_col_in   = pend_col_ff;
      pend_h_in     = pend_h_ff;
      rsp_strobe_in = 1'b0;
      rsp_col_in    = rsp_col_ff;
      rsp_h_in      = rsp_h_ff;
      rsp_pv_in     = rsp_pv_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff[AddrW-1:0];
      wr_data       = '0;
      rd_addr       = idx_ff[AddrW-1:0];

      if (hit) begin
         if (found_ff != '0) begin
            rsp_strobe_in = 1'b1;
            rsp_col_in    = pend_col_ff;
            rsp_h_in      = pend_h_ff;
            rsp_pv_in     = 1'b1;
            rsp_last_in   = 1'b0;
         end
         pend_col_in = q;
         pend_h_in   = sh1_ff;
         prev_in     = q;
         found_in    = found_ff + PeakCapW'(1);
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            idx_in = idx_ff + WidthW'(1);
            if (idx_ff == WidthW'(CountDepth - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            rd_addr = req_column;
            if (start) begin
               col_in   = req_column;
               blank_in = req_cell_blank;
               eof_in   = req_end_of_frame;
               state_in = S_INC;
            end
         end
         S_INC: begin
            wr_addr = col_ff;
            wr_data = rd_data + CountW'(1);
            wr_en   = blank_ff && ({1'b0, col_ff} < w_eff) && (rd_data != CountW'(CountMax));
            if (eof_ff) begin
               idx_in   = '0;
               found_in = '0;
               prev_in  = '0;
               state_in = S_SCAN;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            wr_en  = !idx_ff[WidthW-1];
            v1_in  = 1'b1;
            j1_in  = idx_ff;
            idx_in = idx_ff + WidthW'(1);
            if (idx_ff == WidthW'(CountDepth)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!v1_ff && !v2_ff) begin
               state_in = S_FINAL;
            end
         end
         S_FINAL: begin
            rsp_strobe_in = 1'b1;
            rsp_pv_in     = (found_ff != '0);
            rsp_col_in    = (found_ff != '0) ? pend_col_ff : '0;
            rsp_h_in      = (found_ff != '0) ? pend_h_ff : '0;
            rsp_last_in   = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_CLEAR;
         idx_ff            <= '0;
         v1_ff             <= 1'b0;
         v2_ff             <= 1'b0;
         found_ff          <= '0;
         prev_ff           <= '0;
         rsp_strobe_ff     <= 1'b0;
         frame_width_ff    <= WidthW'(150);
         peak_threshold_ff <= HeightW'(10);
         min_separation_ff <= 8'd5;
         max_peaks_ff      <= PeakCapW'(8);
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         v1_ff         <= v1_in;
         v2_ff         <= v1_ff;
         found_ff      <= found_in;
         prev_ff       <= prev_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid) begin
            case (csr_index)
               RegFrameWidth:    frame_width_ff    <= csr_data;
               RegPeakThreshold: peak_threshold_ff <= csr_data[HeightW-1:0];
               RegMinSeparation: min_separation_ff <= csr_data[7:0];
               RegMaxPeaks:      max_peaks_ff      <= csr_data[PeakCapW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff      <= col_in;
      blank_ff    <= blank_in;
      eof_ff      <= eof_in;
      j1_ff       <= j1_in;
      pend_col_ff <= pend_col_in;
      pend_h_ff   <= pend_h_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_h_ff    <= rsp_h_in;
      rsp_pv_ff   <= rsp_pv_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == S_INC) begin
         cm1_ff <= '0;
         cm2_ff <= '0;
      end else if (v1_ff) begin
         cm1_ff <= cval;
         cm2_ff <= cm1_ff;
         sh2_ff <= sum_sat;
         sh1_ff <= sh2_ff;
         sh0_ff <= sh1_ff;
         j2_ff  <= j1_ff;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_peak_column = rsp_col_ff;
   assign rsp_peak_height = rsp_h_ff;
   assign rsp_peak_valid  = rsp_pv_ff;
   assign rsp_last_result = rsp_last_ff;

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top
   import cbpd_pkg::*;
();

   typedef struct packed {
      logic [7:0]         column;
      logic [HeightW-1:0] height;
      logic               valid;
      logic               last;
   } peak_word_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               start;
   logic               busy;
   logic [7:0]         req_column;
   logic               req_cell_blank;
   logic               req_end_of_frame;
   logic               rsp_strobe;
   logic [7:0]         rsp_peak_column;
   logic [HeightW-1:0] rsp_peak_height;
   logic               rsp_peak_valid;
   logic               rsp_last_result;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [WidthW-1:0]  csr_data;

   logic [WidthW-1:0]   cfg_width      = 9'd150;
   logic [HeightW-1:0]  cfg_threshold  = 7'd10;
   logic [7:0]          cfg_separation = 8'd5;
   logic [PeakCapW-1:0] cfg_max_peaks  = 4'd8;
   logic [CountW-1:0]   col_blanks [CountDepth];

   peak_word_type expected_peaks [$];
   peak_word_type want_peak;
   int         mismatches = 0;
   int         words_sent = 0;
   int         burst_left = 0;

   column_blank_peak_detector dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_column       (req_column),
      .req_cell_blank   (req_cell_blank),
      .req_end_of_frame (req_end_of_frame),
      .rsp_strobe       (rsp_strobe),
      .rsp_peak_column  (rsp_peak_column),
      .rsp_peak_height  (rsp_peak_height),
      .rsp_peak_valid   (rsp_peak_valid),
      .rsp_last_result  (rsp_last_result),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int smoothed(int p, int w);
      int sum;
      sum = 0;
      for (int i = p - 1; i <= p + 1; i++) begin
         if (i >= 0 && i < w) sum += col_blanks[i];
      end
      return (sum > HeightMax) ? HeightMax : sum;
   endfunction

   // Counts one cell and, on the last cell of a frame, scans for peaks.
   task automatic tally_cell(input logic [7:0] col, input logic blank, input logic eof);
      int         w;
      int         cap;
      int         found;
      int         prev;
      int         s;
      bit         have_held;
      peak_word_type held;
      w = (cfg_width > CountDepth) ? CountDepth : int'(cfg_width);
      if (blank && col < w && col_blanks[col] != CountMax) col_blanks[col]++;
      if (!eof) return;
      cap = (cfg_max_peaks == 0) ? 1 : ((cfg_max_peaks > PeakSlots) ? PeakSlots
                                                                     : int'(cfg_max_peaks));
      found = 0;
      prev = 0;
      have_held = 1'b0;
      for (int p = 1; p + 1 < w && found < cap; p++) begin
         s = smoothed(p, w);
         if (s >= smoothed(p - 1, w) && s > smoothed(p + 1, w) && s >= cfg_threshold &&
             (found == 0 || p - prev > cfg_separation)) begin
            if (have_held) expected_peaks.push_back(held);
            held = '{column: p[7:0], height: s[HeightW-1:0], valid: 1'b1, last: 1'b0};
            have_held = 1'b1;
            prev = p;
            found++;
         end
      end
      if (have_held) begin
         held.last = 1'b1;
         expected_peaks.push_back(held);
      end else begin
         expected_peaks.push_back('{column: '0, height: '0, valid: 1'b0, last: 1'b1});
      end
      foreach (col_blanks[i]) col_blanks[i] = '0;
   endtask

   task automatic send_word(input logic [7:0] col, input logic blank, input logic eof);
      start            <= 1'b1;
      req_column       <= col;
      req_cell_blank   <= blank;
      req_end_of_frame <= eof;
      do @(posedge clock); while (busy);
      words_sent++;
      tally_cell(col, blank, eof);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(15, 40)
                                                  : $urandom_range(0, 5);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (expected_peaks.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic set_config(input logic [8:0] width, input logic [8:0] thr,
                             input logic [8:0] sep, input logic [8:0] cap);
      logic [1:0] idx [4];
      logic [8:0] val [4];
      idx = '{RegFrameWidth, RegPeakThreshold, RegMinSeparation, RegMaxPeaks};
      val = '{width, thr, sep, cap};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[i];
         csr_data  <= val[i];
         do @(posedge clock); while (!csr_ready);
         case (idx[i])
            RegFrameWidth:    cfg_width      = val[i];
            RegPeakThreshold: cfg_threshold  = val[i][HeightW-1:0];
            RegMinSeparation: cfg_separation = val[i][7:0];
            RegMaxPeaks:      cfg_max_peaks  = val[i][PeakCapW-1:0];
            default: ;
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_word(8'd0, 1'b0, 1'b1);
      send_word(8'd149, 1'b1, 1'b0);
      send_word(8'd150, 1'b1, 1'b1);
   endtask

   task automatic test_narrow_frames();
      wait_idle();
      set_config(9'd3, 9'd0, 9'd0, 9'd1);
      send_word(8'd0, 1'b1, 1'b1);
      send_word(8'd2, 1'b1, 1'b1);
      wait_idle();
      set_config(9'd2, 9'd0, 9'd0, 9'd1);
      send_word(8'd0, 1'b1, 1'b0);
      send_word(8'd1, 1'b1, 1'b1);
   endtask

   task automatic test_wide_frame();
      wait_idle();
      set_config(9'h1FF, 9'd1, 9'd0, 9'd15);
      send_word(8'd255, 1'b1, 1'b0);
      send_word(8'd254, 1'b1, 1'b0);
      send_word(8'd0, 1'b1, 1'b0);
      send_word(8'd1, 1'b1, 1'b0);
      send_word(8'd128, 1'b1, 1'b0);
      send_word(8'd127, 1'b1, 1'b0);
      send_word(8'd200, 1'b0, 1'b1);
   endtask

   task automatic test_separation_cap();
      logic [7:0] cols [6];
      cols = '{8'd4, 8'd5, 8'd8, 8'd9, 8'd12, 8'd13};
      for (int k = 0; k < 2; k++) begin
         wait_idle();
         if (k == 0) set_config(9'd32, 9'd2, 9'd3, 9'd2);
         else        set_config(9'd32, 9'd2, 9'd4, 9'd0);
         foreach (cols[i]) send_word(cols[i], 1'b1, 1'b0);
         send_word(8'd30, 1'b0, 1'b1);
      end
   endtask

   // Drives two columns past the count limit so that the smoothed sum also clips.
   task automatic test_count_saturation();
      wait_idle();
      set_config(9'd8, 9'd96, 9'd0, 9'd8);
      for (int i = 0; i < 142; i++) begin
         send_word((i < 10) ? 8'd2 : ((i % 2) ? 8'd3 : 8'd4), 1'b1, i == 141);
      end
   endtask

   task automatic send_random_frame();
      int span;
      int len;
      int shape;
      int n_centres;
      int col;
      int centre [3];
      span = (cfg_width < 3) ? 16 : ((cfg_width > CountDepth) ? CountDepth : int'(cfg_width));
      shape = $urandom_range(0, 9);
      len = (shape == 1) ? $urandom_range(1, 3) : $urandom_range(6, 30);
      n_centres = $urandom_range(1, 3);
      for (int k = 0; k < 3; k++) centre[k] = $urandom_range(0, span - 1);
      for (int k = 0; k < len; k++) begin
         if (shape == 0 || $urandom_range(0, 15) == 0) begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), k == len - 1);
         end else begin
            col = centre[$urandom_range(0, n_centres - 1)] + int'($urandom_range(0, 4)) - 2;
            if (col < 0) col = 0;
            if (col > span - 1) col = span - 1;
            send_word(col[7:0], $urandom_range(0, 7) != 0, k == len - 1);
         end
      end
   endtask

   task automatic test_random_frames();
      int goal;
      goal = 480;
      for (int phase = 0; words_sent < goal; phase++) begin
         wait_idle();
         case (phase)
            0: set_config(9'd3, 9'd0, 9'd0, 9'd1);
            1: set_config(9'd256, 9'd96, 9'd255, 9'd8);
            2: set_config(9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF);
            3: set_config(9'd0, 9'd1, 9'd1, 9'd0);
            default: set_config(9'(($urandom_range(0, 7) == 0) ? $urandom_range(49, 300)
                                                               : $urandom_range(3, 40)),
                                9'($urandom_range(0, 6) | ($urandom_range(0, 3) << 7)),
                                9'($urandom_range(0, 8) | ($urandom_range(0, 1) << 8)),
                                9'($urandom_range(0, 15) | ($urandom_range(0, 31) << 4)));
         endcase
         repeat ($urandom_range(2, 6)) send_random_frame();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_peaks.size() == 0) begin
            if (mismatches < 10)
               $display("unexpected result word: col %0d height %0d valid %b last %b",
                        rsp_peak_column, rsp_peak_height, rsp_peak_valid, rsp_last_result);
            mismatches++;
         end else begin
            want_peak = expected_peaks.pop_front();
            if (rsp_peak_column !== want_peak.column || rsp_peak_height !== want_peak.height ||
                rsp_peak_valid !== want_peak.valid || rsp_last_result !== want_peak.last) begin
               if (mismatches < 10)
                  $display("result mismatch: expected col %0d height %0d valid %b last %b,",
                           want_peak.column, want_peak.height, want_peak.valid, want_peak.last,
                           " got col %0d height %0d valid %b last %b",
                           rsp_peak_column, rsp_peak_height, rsp_peak_valid, rsp_last_result);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      foreach (col_blanks[i]) col_blanks[i] = '0;
      reset            <= 1'b1;
      start            <= 1'b0;
      req_column       <= '0;
      req_cell_blank   <= 1'b0;
      req_end_of_frame <= 1'b0;
      csr_valid        <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_narrow_frames();
      test_wide_frame();
      test_separation_cap();
      test_count_saturation();
      test_random_frames();
      wait_idle();
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
